// ===== rtl/ufq_pkg.sv =====
// Package for the urgent-first queue: operation codes, controller states,
// parameter defaults and the command/status structs between control and datapath.
// No dependencies.
package ufq_pkg;

   localparam int QUEUE_DEPTH_DEF   = 16;
   localparam int ID_BITS_DEF       = 16;
   localparam int SEVERITY_BITS_DEF = 4;
   localparam int CRITICAL_RESET    = 5;
   localparam int KIND_W            = 3;

   typedef enum logic [KIND_W-1:0] {
      OP_ENQUEUE = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_PEEK    = 3'd2,
      OP_FIND    = 3'd3,
      OP_LIST    = 3'd4,
      OP_CLEAR   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT,
      ST_LIST
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;   // capture the request beat
      logic scan;       // register the pick index and hit flag
      logic commit;     // apply the operation and load its single result
      logic list_step;  // emit one listed entry
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              fill_zero;
      logic              list_end;
      logic              out_free;
   } status_type;

endpackage

// ===== rtl/ufq_ctrl.sv =====
// Controller state machine for the urgent-first queue.
// Depends on ufq_pkg; drives ufq_dp through cmd_type and reads status_type.
module ufq_ctrl
   import ufq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.kind == OP_LIST && !stat.fill_zero) begin
               state_in = ST_LIST;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_LIST: begin
            if (stat.out_free) begin
               cmd.list_step = 1'b1;
               if (stat.list_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ufq_dp.sv =====
// Datapath for the urgent-first queue: entry row, compare and pick, compaction,
// threshold register and the result register. Depends on ufq_pkg.
module ufq_dp
   import ufq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int ID_BITS       = ID_BITS_DEF,
   parameter int SEVERITY_BITS = SEVERITY_BITS_DEF,
   localparam int IDX_W        = $clog2(QUEUE_DEPTH),
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               stat,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [ID_BITS-1:0]       req_patient_id,
   input  logic [SEVERITY_BITS-1:0] req_severity,
   input  logic                     csr_we,
   input  logic [SEVERITY_BITS-1:0] csr_wdata,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_found,
   output logic [ID_BITS-1:0]       rsp_out_id,
   output logic [SEVERITY_BITS-1:0] rsp_out_severity,
   output logic                     rsp_refused,
   output logic [CNT_W-1:0]         rsp_count,
   output logic                     rsp_last
);

   logic [KIND_W-1:0]        kind_ff;
   logic [ID_BITS-1:0]       pid_ff;
   logic [SEVERITY_BITS-1:0] sev_ff;
   logic [SEVERITY_BITS-1:0] thr_ff;

   logic [ID_BITS-1:0]       ids_ff  [QUEUE_DEPTH];
   logic [SEVERITY_BITS-1:0] sevs_ff [QUEUE_DEPTH];
   logic [CNT_W-1:0]         fill_ff;
   logic [CNT_W-1:0]         fill_in;

   logic [IDX_W-1:0]         pick_ff;
   logic                     hit_ff;
   logic [IDX_W-1:0]         list_idx_ff;

   logic [QUEUE_DEPTH-1:0]   crit_vec;
   logic [QUEUE_DEPTH-1:0]   id_vec;
   logic [QUEUE_DEPTH-1:0]   sel_vec;
   logic [QUEUE_DEPTH-1:0]   low_vec;
   logic [IDX_W-1:0]         pick_in;

   logic                     full;
   logic                     enq_we;
   logic                     shift_en;
   logic [IDX_W-1:0]         rd_idx;
   logic [ID_BITS-1:0]       rd_id;
   logic [SEVERITY_BITS-1:0] rd_sev;

   logic                     out_load;
   logic                     found_in;
   logic                     refused_in;
   logic                     last_in;
   logic [CNT_W-1:0]         count_in;

   logic                     rsp_valid_ff;
   logic                     found_ff;
   logic [ID_BITS-1:0]       out_id_ff;
   logic [SEVERITY_BITS-1:0] out_sev_ff;
   logic                     refused_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     last_ff;

   assign full = (fill_ff == CNT_W'(QUEUE_DEPTH));

   // Request and threshold registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kind_ff <= req_kind;
         pid_ff  <= req_patient_id;
         sev_ff  <= req_severity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= SEVERITY_BITS'(CRITICAL_RESET);
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   // Parallel compare over the held entries, then pick the oldest hit.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         crit_vec[i] = (CNT_W'(i) < fill_ff) && (sevs_ff[i] >= thr_ff);
         id_vec[i]   = (CNT_W'(i) < fill_ff) && (ids_ff[i] == pid_ff);
      end
   end

   assign sel_vec = (kind_ff == OP_FIND) ? id_vec : crit_vec;
   // isolate the lowest set bit, then encode it
   assign low_vec = sel_vec & (~sel_vec + QUEUE_DEPTH'(1));

   always_comb begin
      pick_in = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (low_vec[i]) begin
            pick_in = pick_in | IDX_W'(i);
         end
      end
   end

   // No critical hit leaves the pick at zero: serve the oldest entry.
   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         pick_ff <= pick_in;
         hit_ff  <= |sel_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         list_idx_ff <= '0;
      end else if (cmd.list_step) begin
         list_idx_ff <= list_idx_ff + IDX_W'(1);
      end
   end

   assign rd_idx = cmd.list_step ? list_idx_ff : pick_ff;
   assign rd_id  = ids_ff[rd_idx];
   assign rd_sev = sevs_ff[rd_idx];

   // Operation decode for the single-result path and the list path.
   always_comb begin
      out_load   = 1'b0;
      enq_we     = 1'b0;
      shift_en   = 1'b0;
      found_in   = 1'b0;
      refused_in = 1'b0;
      last_in    = 1'b1;
      fill_in    = fill_ff;
      if (cmd.list_step) begin
         out_load = 1'b1;
         found_in = 1'b1;
         last_in  = stat.list_end;
      end else if (cmd.commit) begin
         out_load = 1'b1;
         case (kind_ff)
            OP_ENQUEUE: begin
               if (full) begin
                  refused_in = 1'b1;
               end else begin
                  enq_we  = 1'b1;
                  fill_in = fill_ff + CNT_W'(1);
               end
            end
            OP_DEQUEUE: begin
               if (!stat.fill_zero) begin
                  found_in = 1'b1;
                  shift_en = 1'b1;
                  fill_in  = fill_ff - CNT_W'(1);
               end
            end
            OP_PEEK: begin
               found_in = !stat.fill_zero;
            end
            OP_FIND: begin
               found_in = hit_ff;
            end
            OP_CLEAR: begin
               fill_in = '0;
            end
            default: begin
               found_in = 1'b0;
            end
         endcase
      end
      count_in = fill_in;
   end

   // Entry row: close the gap behind a removed entry, append at the tail.
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (shift_en && (IDX_W'(i) >= pick_ff) && (i < QUEUE_DEPTH - 1)) begin
            ids_ff[i]  <= ids_ff[(i + 1) % QUEUE_DEPTH];
            sevs_ff[i] <= sevs_ff[(i + 1) % QUEUE_DEPTH];
         end else if (enq_we && (fill_ff[IDX_W-1:0] == IDX_W'(i))) begin
            ids_ff[i]  <= pid_ff;
            sevs_ff[i] <= sev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         found_ff   <= found_in;
         out_id_ff  <= found_in ? rd_id : '0;
         out_sev_ff <= found_in ? rd_sev : '0;
         refused_ff <= refused_in;
         count_ff   <= count_in;
         last_ff    <= last_in;
      end
   end

   assign stat.kind      = kind_ff;
   assign stat.fill_zero = (fill_ff == '0);
   assign stat.list_end  = ((CNT_W'(list_idx_ff) + CNT_W'(1)) == fill_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = found_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_severity = out_sev_ff;
   assign rsp_refused      = refused_ff;
   assign rsp_count        = count_ff;
   assign rsp_last         = last_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("fill count beyond queue depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (kind_ff == OP_CLEAR) |=> fill_ff == '0)
      else $error("clear left entries behind");

   a_no_load_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !out_load)
      else $error("result overwritten while stalled");

   a_empty_beat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> (out_id_ff == '0) && (out_sev_ff == '0))
      else $error("entry fields set on a beat without an entry");

   a_refused_when_full: assert property (@(posedge clock) disable iff (reset)
      out_load && refused_in |-> full && (kind_ff == OP_ENQUEUE))
      else $error("refusal without a full queue");
`endif

endmodule

// ===== rtl/urgent_first_fifo_queue.sv =====
// Urgent-first queue: an item is taken in the idle state, scanned in the scan state, and
// its result is registered in the result state; a new item is taken only back in idle.
// A list of N entries gives one beat per entry, read through the single read port on
// the entry row. A stalled rsp side holds
// the controller before it applies the next operation.
// Reset clears the fill count and result valid and sets the threshold to 5.
module urgent_first_fifo_queue
   import ufq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
   parameter int ID_BITS       = ID_BITS_DEF,
   parameter int SEVERITY_BITS = SEVERITY_BITS_DEF,
   localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1)
)
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [ID_BITS-1:0]       req_patient_id,
   input  logic [SEVERITY_BITS-1:0] req_severity,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_found,
   output logic [ID_BITS-1:0]       rsp_out_id,
   output logic [SEVERITY_BITS-1:0] rsp_out_severity,
   output logic                     rsp_refused,
   output logic [CNT_W-1:0]         rsp_count,
   output logic                     rsp_last,
   // critical threshold register
   input  logic                     csr_we,
   input  logic [SEVERITY_BITS-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type stat;

   // Controller: sequence accept, scan, then one commit beat or a run of list beats.
   ufq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: entry row with compaction, parallel compare, pick, result register.
   ufq_dp #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .ID_BITS       (ID_BITS),
      .SEVERITY_BITS (SEVERITY_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_patient_id   (req_patient_id),
      .req_severity     (req_severity),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_severity (rsp_out_severity),
      .rsp_refused      (rsp_refused),
      .rsp_count        (rsp_count),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== tb/ufq_checker.sv =====
// Checker for the urgent-first queue: keeps its own copy of the queue and threshold,
// predicts the response beats of every accepted request and compares them in order.
// Depends on ufq_pkg for the operation codes and the default sizes.
module ufq_checker
   import ufq_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [KIND_W-1:0]            req_kind,
   input  logic [ID_BITS_DEF-1:0]       req_patient_id,
   input  logic [SEVERITY_BITS_DEF-1:0] req_severity,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_found,
   input  logic [ID_BITS_DEF-1:0]       rsp_out_id,
   input  logic [SEVERITY_BITS_DEF-1:0] rsp_out_severity,
   input  logic                         rsp_refused,
   input  logic [$clog2(QUEUE_DEPTH_DEF+1)-1:0] rsp_count,
   input  logic                         rsp_last,
   input  logic                         csr_we,
   input  logic [SEVERITY_BITS_DEF-1:0] csr_wdata,
   output int unsigned                  mismatches,
   output int unsigned                  beats_due
);

   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam int ID_W  = ID_BITS_DEF;
   localparam int SEV_W = SEVERITY_BITS_DEF;
   localparam int CNT_W = $clog2(DEPTH + 1);
   // room for one waiting beat plus a full list
   localparam int RING_DEPTH = 64;

   typedef struct packed {
      logic             found;
      logic [ID_W-1:0]  id;
      logic [SEV_W-1:0] sev;
      logic             refused;
      logic [CNT_W-1:0] count;
      logic             last;
   } queue_beat_type;

   logic [ID_W-1:0]  held_id  [DEPTH];
   logic [SEV_W-1:0] held_sev [DEPTH];
   int unsigned      held_count;
   logic [SEV_W-1:0] urgent_level;
   queue_beat_type   expected_ring [RING_DEPTH];
   int unsigned      ring_rd;
   int unsigned      ring_wr;
   int unsigned      ring_used;

   function automatic void add_beat(input bit found, input logic [ID_W-1:0] id,
                                    input logic [SEV_W-1:0] sev, input bit refused,
                                    input bit last);
      queue_beat_type b;
      b.found   = found;
      b.id      = found ? id : '0;
      b.sev     = found ? sev : '0;
      b.refused = refused;
      b.count   = CNT_W'(held_count);
      b.last    = last;
      if (ring_used == RING_DEPTH) begin
         $error("expected beat store overflow");
         mismatches++;
      end else begin
         expected_ring[ring_wr] = b;
         ring_wr   = (ring_wr + 1) % RING_DEPTH;
         ring_used++;
      end
   endfunction

   // oldest urgent entry, else the oldest one
   function automatic int unsigned serve_index();
      for (int i = 0; i < held_count; i++)
         if (held_sev[i] >= urgent_level)
            return i;
      return 0;
   endfunction

   function automatic void apply_op(input logic [KIND_W-1:0] kind,
                                    input logic [ID_W-1:0] pid,
                                    input logic [SEV_W-1:0] sev);
      int unsigned      pos;
      logic [ID_W-1:0]  id;
      logic [SEV_W-1:0] sv;
      bit               hit;
      id  = '0;
      sv  = '0;
      hit = 1'b0;
      case (kind)
         OP_ENQUEUE: begin
            if (held_count < DEPTH) begin
               held_id[held_count]  = pid;
               held_sev[held_count] = sev;
               held_count++;
               add_beat(1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
               add_beat(1'b0, '0, '0, 1'b1, 1'b1);
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            if (held_count == 0) begin
               add_beat(1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
               pos = serve_index();
               id  = held_id[pos];
               sv  = held_sev[pos];
               if (kind == OP_DEQUEUE) begin
                  // close the gap, keep arrival order
                  for (int i = pos; i + 1 < held_count; i++) begin
                     held_id[i]  = held_id[i+1];
                     held_sev[i] = held_sev[i+1];
                  end
                  held_count--;
               end
               add_beat(1'b1, id, sv, 1'b0, 1'b1);
            end
         end
         OP_FIND: begin
            for (int i = 0; i < held_count; i++)
               if (!hit && held_id[i] == pid) begin
                  hit = 1'b1;
                  id  = held_id[i];
                  sv  = held_sev[i];
               end
            add_beat(hit, id, sv, 1'b0, 1'b1);
         end
         OP_LIST: begin
            if (held_count == 0)
               add_beat(1'b0, '0, '0, 1'b0, 1'b1);
            else
               for (int i = 0; i < held_count; i++)
                  add_beat(1'b1, held_id[i], held_sev[i], 1'b0, i + 1 == held_count);
         end
         OP_CLEAR: begin
            held_count = 0;
            add_beat(1'b0, '0, '0, 1'b0, 1'b1);
         end
         default: add_beat(1'b0, '0, '0, 1'b0, 1'b1);
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      queue_beat_type want;
      if (reset) begin
         held_count   = 0;
         urgent_level = SEV_W'(CRITICAL_RESET);
         ring_rd      = 0;
         ring_wr      = 0;
         ring_used    = 0;
      end else begin
         if (csr_we)
            urgent_level = csr_wdata;
         // retire response beats before predicting, so a beat never meets its own request
         if (rsp_valid && rsp_ready) begin
            if (ring_used == 0) begin
               $error("response beat with no request waiting");
               mismatches++;
            end else begin
               want      = expected_ring[ring_rd];
               ring_rd   = (ring_rd + 1) % RING_DEPTH;
               ring_used--;
               check_field("found", 32'(want.found), 32'(rsp_found));
               check_field("out_id", 32'(want.id), 32'(rsp_out_id));
               check_field("out_severity", 32'(want.sev), 32'(rsp_out_severity));
               check_field("refused", 32'(want.refused), 32'(rsp_refused));
               check_field("count", 32'(want.count), 32'(rsp_count));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         if (req_valid && req_ready)
            apply_op(req_kind, req_patient_id, req_severity);
      end
      beats_due <= ring_used;
   end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the urgent-first queue: drives requests, threshold writes and
// response back-pressure; the verdict comes from the mismatch count of ufq_checker.
// Depends on ufq_pkg, ufq_checker and the urgent_first_fifo_queue RTL.
module tb;
   import ufq_pkg::*;

   localparam int ID_W  = ID_BITS_DEF;
   localparam int SEV_W = SEVERITY_BITS_DEF;
   localparam int CNT_W = $clog2(QUEUE_DEPTH_DEF + 1);

   // kind codes the block treats as no-ops
   localparam logic [KIND_W-1:0] OP_UNUSED_LO = 3'd6;
   localparam logic [KIND_W-1:0] OP_UNUSED_HI = 3'd7;

   localparam int unsigned RUN_LIMIT     = 10_000_000;
   localparam int unsigned PHASE_ITEMS   = 60;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic             clock;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   logic [KIND_W-1:0] req_kind      = '0;
   logic [ID_W-1:0]  req_patient_id = '0;
   logic [SEV_W-1:0] req_severity   = '0;
   logic             rsp_valid;
   logic             rsp_ready      = 1'b0;
   logic             rsp_found;
   logic [ID_W-1:0]  rsp_out_id;
   logic [SEV_W-1:0] rsp_out_severity;
   logic             rsp_refused;
   logic [CNT_W-1:0] rsp_count;
   logic             rsp_last;
   logic             csr_we         = 1'b0;
   logic [SEV_W-1:0] csr_wdata      = '0;

   int unsigned      mismatches;
   int unsigned      beats_due;
   // while set, neither side idles
   logic             steady_flow    = 1'b0;
   // small set of ids so that finds hit now and then
   logic [ID_W-1:0]  id_pool [8];

   urgent_first_fifo_queue u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_patient_id   (req_patient_id),
      .req_severity     (req_severity),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_severity (rsp_out_severity),
      .rsp_refused      (rsp_refused),
      .rsp_count        (rsp_count),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   ufq_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_patient_id   (req_patient_id),
      .req_severity     (req_severity),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_severity (rsp_out_severity),
      .rsp_refused      (rsp_refused),
      .rsp_count        (rsp_count),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .mismatches       (mismatches),
      .beats_due        (beats_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(RUN_LIMIT);
      $display("status: fail");
      $finish;
   end

   // Idle length: mostly none, often short, now and then a long stretch.
   function automatic int unsigned idle_len();
      int unsigned r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one request beat after an optional gap; hold it until accepted.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] pid,
                            input logic [SEV_W-1:0] sev);
      int unsigned gap;
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_patient_id <= pid;
      req_severity   <= sev;
      // req_ready sampled here is its value in the cycle that ends at this edge
      do @(posedge clock); while (!req_ready);
   endtask

   // Draw one random request; enq_pct steers how full the queue tends to run.
   task automatic random_item(input int unsigned enq_pct);
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   pid;
      int unsigned       r;
      r = $urandom_range(0, 99);
      if (r < enq_pct) begin
         kind = OP_ENQUEUE;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 40)
            kind = OP_DEQUEUE;
         else if (r < 55)
            kind = OP_PEEK;
         else if (r < 75)
            kind = OP_FIND;
         else if (r < 87)
            kind = OP_LIST;
         else if (r < 93)
            kind = OP_CLEAR;
         else
            kind = $urandom_range(0, 1) ? OP_UNUSED_HI : OP_UNUSED_LO;
      end
      pid = ($urandom_range(0, 99) < 60) ? id_pool[$urandom_range(0, 7)] : ID_W'($urandom);
      send_item(kind, pid, SEV_W'($urandom_range(0, 15)));
   endtask

   // Drop valid and hold until every predicted beat has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      // first let the checker's count take in the last accepted request
      @(posedge clock);
      while (beats_due != 0) @(posedge clock);
   endtask

   // Write the threshold; the block is idle whenever this is called.
   task automatic write_threshold(input logic [SEV_W-1:0] level);
      csr_we    <= 1'b1;
      csr_wdata <= level;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Response side: random stalls, released by steady_flow.
   initial begin
      int unsigned stall;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         stall = idle_len();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   initial begin
      int unsigned level_plan [5] = '{0, 15, 9, 1, 0};
      int unsigned enq_plan   [5] = '{55, 80, 50, 70, 60};
      logic [SEV_W-1:0] lvl;
      logic [SEV_W-1:0] sev;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, threshold at its reset value.
      // Empty queue: dequeue, peek and list each give one empty beat.
      send_item(OP_DEQUEUE, '0, '0);
      send_item(OP_PEEK, '0, '0);
      send_item(OP_LIST, '0, '0);
      // Fill to the brim: id 0 / all-ones, severity 0 / 15, urgent entries
      // sitting behind older calm ones.
      for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
         if (i == 0)
            sev = '0;
         else if (i == 1)
            sev = 4'd4;
         else if (i == 2)
            sev = 4'd5;
         else if (i == 9)
            sev = 4'd15;
         else
            sev = SEV_W'(i % 5);
         send_item(OP_ENQUEUE, (i == 1) ? 16'hFFFF : ID_W'(i * 16'h0F0F), sev);
      end
      // full: this one must be refused
      send_item(OP_ENQUEUE, 16'hAAAA, 4'd15);
      send_item(OP_PEEK, '0, '0);
      send_item(OP_FIND, 16'h2D2D, '0);
      send_item(OP_FIND, 16'hBEEF, '0);
      // sixteen beats, last on the final one only
      send_item(OP_LIST, '0, '0);
      send_item(OP_DEQUEUE, '0, '0);
      send_item(OP_UNUSED_LO, 16'hFFFF, 4'd15);
      send_item(OP_CLEAR, '0, '0);

      // Random phases, each under its own threshold, extremes included.
      for (int p = 0; p < 5; p++) begin
         wait_idle();
         lvl = (p == 4) ? SEV_W'($urandom_range(0, 15)) : SEV_W'(level_plan[p]);
         write_threshold(lvl);
         foreach (id_pool[k])
            id_pool[k] = ID_W'($urandom);
         steady_flow <= (p == 2);
         repeat (PHASE_ITEMS) random_item(enq_plan[p]);
      end

      wait_idle();
      steady_flow <= 1'b0;
      // catch any stray beat the block might still emit
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
